@@ hdl/dsm_pkg.sv @@
// Shared types and constants for the drive safety monitor.
// No dependencies; imported by every module of the block.
package dsm_pkg;

    typedef enum logic [1:0] {
        LVL_SAFE      = 2'd0,
        LVL_WARN      = 2'd1,
        LVL_LIMP      = 2'd2,
        LVL_EMERGENCY = 2'd3
    } level_t;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CUR_LIMP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUR_WARN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_WARN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_TIME = 3'd4;

    localparam logic signed [15:0] LEVEL_RST       = 16'sd32767;
    localparam logic [15:0]        STABLE_TIME_RST = 16'd2000;

    typedef struct packed {
        logic signed [15:0] cur_limp;
        logic signed [15:0] cur_warn;
        logic signed [15:0] temp_limp;
        logic signed [15:0] temp_warn;
        logic [15:0]        stable_time;
    } cfg_t;

    typedef struct packed {
        logic               fault_latched;
        logic signed [15:0] current_a;
        logic signed [15:0] current_b;
        logic signed [15:0] current_c;
        logic signed [15:0] current_d;
        logic signed [15:0] temp_left;
        logic signed [15:0] temp_right;
        logic [31:0]        now_ms;
    } item_t;

    typedef struct packed {
        logic stable_safe;
        logic clear_reverse;
    } stable_out_t;

endpackage

@@ hdl/dsm_cfg_regs.sv @@
// Configuration register file for the drive safety monitor.
// Depends on dsm_pkg for register indexes, reset values and cfg_t.
module dsm_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [dsm_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [dsm_pkg::CFG_DATA_W-1:0]  wr_data,
    output dsm_pkg::cfg_t                   cfg
);
    import dsm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_CUR_LIMP:    cfg_next.cur_limp    = $signed(wr_data);
                REG_CUR_WARN:    cfg_next.cur_warn    = $signed(wr_data);
                REG_TEMP_LIMP:   cfg_next.temp_limp   = $signed(wr_data);
                REG_TEMP_WARN:   cfg_next.temp_warn   = $signed(wr_data);
                REG_STABLE_TIME: cfg_next.stable_time = wr_data;
                default:         cfg_next = cfg_reg;  // drop writes to unused indexes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cur_limp    <= LEVEL_RST;
            cfg_reg.cur_warn    <= LEVEL_RST;
            cfg_reg.temp_limp   <= LEVEL_RST;
            cfg_reg.temp_warn   <= LEVEL_RST;
            cfg_reg.stable_time <= STABLE_TIME_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/dsm_level.sv @@
// Threshold compare and limp/warn confirmation counters.
// Depends on dsm_pkg for item_t, cfg_t and level_t.
module dsm_level #(
    parameter int unsigned LIMP_CONFIRM = 3,
    parameter int unsigned WARN_CONFIRM = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  dsm_pkg::item_t   item,
    input  dsm_pkg::cfg_t    cfg,
    output dsm_pkg::level_t  level
);
    import dsm_pkg::*;

    localparam int unsigned LIMP_W = $clog2(LIMP_CONFIRM + 1);
    localparam int unsigned WARN_W = $clog2(WARN_CONFIRM + 1);
    localparam logic [LIMP_W-1:0] LIMP_MAX = LIMP_W'(LIMP_CONFIRM);
    localparam logic [WARN_W-1:0] WARN_MAX = WARN_W'(WARN_CONFIRM);

    logic [LIMP_W-1:0] limp_count_reg;
    logic [LIMP_W-1:0] limp_count_next;
    logic [WARN_W-1:0] warn_count_reg;
    logic [WARN_W-1:0] warn_count_next;

    logic cur_over_limp;
    logic cur_over_warn;
    logic limp_cond;
    logic warn_cond;
    logic limp_reached;
    logic warn_reached;

    // Any channel above a level is the same as the largest channel above it.
    assign cur_over_limp = ($signed(item.current_a) > $signed(cfg.cur_limp)) ||
                           ($signed(item.current_b) > $signed(cfg.cur_limp)) ||
                           ($signed(item.current_c) > $signed(cfg.cur_limp)) ||
                           ($signed(item.current_d) > $signed(cfg.cur_limp));
    assign cur_over_warn = ($signed(item.current_a) > $signed(cfg.cur_warn)) ||
                           ($signed(item.current_b) > $signed(cfg.cur_warn)) ||
                           ($signed(item.current_c) > $signed(cfg.cur_warn)) ||
                           ($signed(item.current_d) > $signed(cfg.cur_warn));

    assign limp_cond = cur_over_limp ||
                       ($signed(item.temp_left)  > $signed(cfg.temp_limp)) ||
                       ($signed(item.temp_right) > $signed(cfg.temp_limp));
    assign warn_cond = cur_over_warn ||
                       ($signed(item.temp_left)  > $signed(cfg.temp_warn)) ||
                       ($signed(item.temp_right) > $signed(cfg.temp_warn));

    // Count after this beat reaches the confirm level.
    assign limp_reached = (limp_count_reg >= (LIMP_MAX - 1'b1));
    assign warn_reached = (warn_count_reg >= (WARN_MAX - 1'b1));

    always_comb
    begin
        limp_count_next = '0;
        warn_count_next = '0;
        level           = LVL_SAFE;
        priority if (item.fault_latched)
        begin
            level = LVL_EMERGENCY;
        end
        else if (limp_cond)
        begin
            limp_count_next = limp_reached ? LIMP_MAX : (limp_count_reg + 1'b1);
            level           = limp_reached ? LVL_LIMP : LVL_WARN;
        end
        else if (warn_cond)
        begin
            warn_count_next = warn_reached ? WARN_MAX : (warn_count_reg + 1'b1);
            level           = warn_reached ? LVL_WARN : LVL_SAFE;
        end
        else
        begin
            level = LVL_SAFE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limp_count_reg <= '0;
            warn_count_reg <= '0;
        end
        else if (fire)
        begin
            limp_count_reg <= limp_count_next;
            warn_count_reg <= warn_count_next;
        end
    end

endmodule

@@ hdl/dsm_stable.sv @@
// Stability timer: tracks continuous safe time and raises the stable flag.
// Depends on dsm_pkg for level_t and stable_out_t.
module dsm_stable (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  dsm_pkg::level_t     level,
    input  logic [31:0]         now_ms,
    input  logic [15:0]         stable_time,
    output dsm_pkg::stable_out_t status
);
    import dsm_pkg::*;

    logic        stable_reg;
    logic        stable_next;
    logic [31:0] start_reg;
    logic [31:0] start_next;
    logic [31:0] elapsed;
    logic        clear;

    assign elapsed = now_ms - start_reg;

    always_comb
    begin
        stable_next = stable_reg;
        start_next  = start_reg;
        clear       = 1'b0;
        priority if (level != LVL_SAFE)
        begin
            stable_next = 1'b0;
            start_next  = '0;
        end
        else if (!stable_reg)
        begin
            // Zero start time means the timer is not running; load now (may be zero again).
            if (start_reg == '0)
            begin
                start_next = now_ms;
            end
            else if (elapsed >= {16'd0, stable_time})
            begin
                stable_next = 1'b1;
                clear       = 1'b1;
            end
        end
        else
        begin
            // Already stable: hold flag and timer.
            stable_next = stable_reg;
            start_next  = start_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= 1'b0;
            start_reg  <= '0;
        end
        else if (fire)
        begin
            stable_reg <= stable_next;
            start_reg  <= start_next;
        end
    end

    assign status.stable_safe   = stable_next;
    assign status.clear_reverse = clear;

endmodule

@@ hdl/drive_safety_monitor_core.sv @@
// Drive safety monitor top level: input register, evaluation, result register.
// Depends on dsm_pkg, dsm_cfg_regs, dsm_level and dsm_stable.
// Path from input beat to result beat: input register, then result register.
// Throughput: one beat per cycle while out_ready allows; state updates as an item moves into the result register.
// Reset: rst_n asynchronous active low; thresholds 32767, stable time 2000 ms,
// counters, stable flag and safe timer cleared, no beat pending.
module drive_safety_monitor_core #(
    parameter int unsigned LIMP_CONFIRM = 3,
    parameter int unsigned WARN_CONFIRM = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dsm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            fault_latched,
    input  logic signed [15:0]              current_a,
    input  logic signed [15:0]              current_b,
    input  logic signed [15:0]              current_c,
    input  logic signed [15:0]              current_d,
    input  logic signed [15:0]              temp_left,
    input  logic signed [15:0]              temp_right,
    input  logic [31:0]                     now_ms,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      safety_level,
    output logic                            stable_safe,
    output logic                            clear_reverse
);
    import dsm_pkg::*;

    cfg_t        cfg;
    item_t       item_reg;
    logic        item_valid_reg;
    logic        out_valid_reg;
    level_t      level_reg;
    logic        stable_reg;
    logic        clear_reg;
    level_t      level;
    stable_out_t status;
    logic        out_adv;
    logic        fire;
    logic        in_fire;

    assign cfg_ready = 1'b1;

    // Result register frees when empty or taken; input register frees when it moves on.
    assign out_adv  = !out_valid_reg || out_ready;
    assign fire     = item_valid_reg && out_adv;
    assign in_ready = !item_valid_reg || out_adv;
    assign in_fire  = in_valid && in_ready;

    dsm_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    dsm_level #(
        .LIMP_CONFIRM (LIMP_CONFIRM),
        .WARN_CONFIRM (WARN_CONFIRM)
    ) u_level (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg),
        .level (level)
    );

    dsm_stable u_stable (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .level       (level),
        .now_ms      (item_reg.now_ms),
        .stable_time (cfg.stable_time),
        .status      (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= item_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.fault_latched <= fault_latched;
            item_reg.current_a     <= current_a;
            item_reg.current_b     <= current_b;
            item_reg.current_c     <= current_c;
            item_reg.current_d     <= current_d;
            item_reg.temp_left     <= temp_left;
            item_reg.temp_right    <= temp_right;
            item_reg.now_ms        <= now_ms;
        end
        if (fire)
        begin
            level_reg  <= level;
            stable_reg <= status.stable_safe;
            clear_reg  <= status.clear_reverse;
        end
    end

    assign out_valid     = out_valid_reg;
    assign safety_level  = level_reg;
    assign stable_safe   = stable_reg;
    assign clear_reverse = clear_reg;

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for drive_safety_monitor_core: directed and random ticks,
// checked against an in-bench predictor of levels, confirm counters and the safe timer.
// Depends on dsm_pkg and the drive_safety_monitor_core RTL.
`timescale 1ns / 100ps

module tb_top;
    import dsm_pkg::*;

    localparam int unsigned LIMP_TICKS   = 3;
    localparam int unsigned WARN_TICKS   = 2;
    localparam int          PIPE_LATENCY = 2;
    localparam int          PHASE_ITEMS  = 155;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_STABLE_TIME + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

    typedef struct {
        level_t level;
        logic   stable;
        logic   clear;
    } verdict_t;

    class safety_ledger;
        logic signed [15:0] cur_limp;
        logic signed [15:0] cur_warn;
        logic signed [15:0] temp_limp;
        logic signed [15:0] temp_warn;
        logic [15:0]        stable_time;
        int unsigned        limp_run;
        int unsigned        warn_run;
        logic               stable_flag;
        logic [31:0]        safe_since;
        verdict_t           verdict_q[$];
        int                 errors;

        function new();
            cur_limp    = LEVEL_RST;
            cur_warn    = LEVEL_RST;
            temp_limp   = LEVEL_RST;
            temp_warn   = LEVEL_RST;
            stable_time = STABLE_TIME_RST;
            limp_run    = 0;
            warn_run    = 0;
            stable_flag = 1'b0;
            safe_since  = '0;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_CUR_LIMP:    cur_limp = data;
                REG_CUR_WARN:    cur_warn = data;
                REG_TEMP_LIMP:   temp_limp = data;
                REG_TEMP_WARN:   temp_warn = data;
                REG_STABLE_TIME: stable_time = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        // Work out the verdict of one accepted tick and advance the state.
        function void judge_tick(item_t it);
            logic signed [15:0] peak;
            logic signed [15:0] t_l;
            logic signed [15:0] t_r;
            logic signed [15:0] cur[4];
            logic [31:0]        elapsed;
            verdict_t           v;
            v.clear = 1'b0;
            cur[0] = it.current_a;
            cur[1] = it.current_b;
            cur[2] = it.current_c;
            cur[3] = it.current_d;
            t_l = it.temp_left;
            t_r = it.temp_right;
            if (it.fault_latched) begin
                limp_run = 0;
                warn_run = 0;
                v.level = LVL_EMERGENCY;
            end
            else begin
                peak = cur[0];
                for (int i = 1; i < 4; i++)
                begin
                    if (cur[i] > peak)
                        peak = cur[i];
                end
                if (peak > cur_limp || t_l > temp_limp || t_r > temp_limp) begin
                    warn_run = 0;
                    limp_run++;
                    if (limp_run >= LIMP_TICKS) begin
                        limp_run = LIMP_TICKS;
                        v.level  = LVL_LIMP;
                    end
                    else
                        v.level = LVL_WARN;
                end
                else if (peak > cur_warn || t_l > temp_warn || t_r > temp_warn) begin
                    limp_run = 0;
                    warn_run++;
                    if (warn_run >= WARN_TICKS) begin
                        warn_run = WARN_TICKS;
                        v.level  = LVL_WARN;
                    end
                    else
                        v.level = LVL_SAFE;
                end
                else begin
                    limp_run = 0;
                    warn_run = 0;
                    v.level  = LVL_SAFE;
                end
            end
            if (v.level != LVL_SAFE) begin
                stable_flag = 1'b0;
                safe_since  = '0;
            end
            else if (!stable_flag) begin
                // zero start time means the timer has not started yet
                if (safe_since == '0)
                    safe_since = it.now_ms;
                else begin
                    elapsed = it.now_ms - safe_since;
                    if (elapsed >= {16'd0, stable_time}) begin
                        stable_flag = 1'b1;
                        v.clear     = 1'b1;
                    end
                end
            end
            v.stable = stable_flag;
            verdict_q.push_back(v);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
            errors++;
        endtask

        task check_verdict(logic [1:0] level, logic stable, logic clear);
            verdict_t v;
            if (verdict_q.size() == 0) begin
                report_mismatch("unexpected result beat", 1, 0);
                return;
            end
            v = verdict_q.pop_front();
            if (level !== v.level)
                report_mismatch("safety_level", level, v.level);
            if (stable !== v.stable)
                report_mismatch("stable_safe", stable, v.stable);
            if (clear !== v.clear)
                report_mismatch("clear_reverse", clear, v.clear);
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  fault_latched;
    logic signed [15:0]    current_a;
    logic signed [15:0]    current_b;
    logic signed [15:0]    current_c;
    logic signed [15:0]    current_d;
    logic signed [15:0]    temp_left;
    logic signed [15:0]    temp_right;
    logic [31:0]           now_ms;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            safety_level;
    logic                  stable_safe;
    logic                  clear_reverse;

    safety_ledger ledger = new();
    int           send_idle_pct;
    int           recv_stall_pct;
    logic [31:0]  tick_ms;

    drive_safety_monitor_core #(
        .LIMP_CONFIRM (LIMP_TICKS),
        .WARN_CONFIRM (WARN_TICKS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .fault_latched (fault_latched),
        .current_a     (current_a),
        .current_b     (current_b),
        .current_c     (current_c),
        .current_d     (current_d),
        .temp_left     (temp_left),
        .temp_right    (temp_right),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .safety_level  (safety_level),
        .stable_safe   (stable_safe),
        .clear_reverse (clear_reverse)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            ledger.check_verdict(safety_level, stable_safe, clear_reverse);
        out_ready <= (int'($urandom_range(0, 99)) >= recv_stall_pct);
    end

    function automatic item_t mk(logic f, int a, int b, int c, int d, int tl, int tr,
                                 logic [31:0] now);
        item_t it;
        it.fault_latched = f;
        it.current_a     = a[15:0];
        it.current_b     = b[15:0];
        it.current_c     = c[15:0];
        it.current_d     = d[15:0];
        it.temp_left     = tl[15:0];
        it.temp_right    = tr[15:0];
        it.now_ms        = now;
        return it;
    endfunction

    // Value not above lim, often at or just below it.
    function automatic int at_most(int lim);
        int v;
        if ($urandom_range(0, 1))
            v = lim - int'($urandom_range(0, 3));
        else
            v = -32768 + int'($urandom_range(0, lim + 32768));
        return (v < -32768) ? -32768 : v;
    endfunction

    // Value strictly in (lo, hi]; falls back to at_most(hi) when that is empty.
    function automatic int between(int lo, int hi);
        if (lo >= hi)
            return at_most(hi);
        if ($urandom_range(0, 1))
            return lo + 1 + int'($urandom_range(0, (hi - lo - 1 < 3) ? hi - lo - 1 : 3));
        return lo + 1 + int'($urandom_range(0, hi - lo - 1));
    endfunction

    task automatic send_tick(item_t it);
        while (int'($urandom_range(0, 99)) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        fault_latched <= it.fault_latched;
        current_a     <= it.current_a;
        current_b     <= it.current_b;
        current_c     <= it.current_c;
        current_d     <= it.current_d;
        temp_left     <= it.temp_left;
        temp_right    <= it.temp_right;
        now_ms        <= it.now_ms;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ledger.judge_tick(it);
    endtask

    // Drop valid and hold until every pending verdict has come back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ledger.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        ledger.set_reg(idx, data);
    endtask

    task automatic apply_setting(int k);
        int cl;
        int cw;
        int tl;
        int tw;
        int st;
        case (k)
            0: begin
                cl = 800; cw = 480; tl = 1440; tw = 1280; st = 3;
            end
            1: begin
                cl = -32768; cw = -32768; tl = -32768; tw = -32768; st = 0;
            end
            2: begin
                cl = 32767; cw = 32767; tl = 32767; tw = 32767; st = 65535;
            end
            4: begin
                // warn levels above limp levels: warn can only come from the limp path
                cl = $urandom_range(400, 1600);
                cw = cl + int'($urandom_range(1, 400));
                tl = $urandom_range(800, 2000);
                tw = tl + int'($urandom_range(1, 400));
                st = $urandom_range(0, 500);
            end
            5: begin
                cl = $urandom_range(0, 65535);
                cw = $urandom_range(0, 65535);
                tl = $urandom_range(0, 65535);
                tw = $urandom_range(0, 65535);
                st = $urandom_range(0, 65535);
            end
            default: begin
                cl = $urandom_range(400, 1600);
                cw = cl - int'($urandom_range(0, 400));
                tl = $urandom_range(800, 2000);
                tw = tl - int'($urandom_range(0, 400));
                st = (k == 3) ? int'($urandom_range(1, 3000)) : 0;
            end
        endcase
        write_reg(REG_CUR_LIMP, cl[15:0]);
        write_reg(REG_CUR_WARN, cw[15:0]);
        write_reg(REG_TEMP_LIMP, tl[15:0]);
        write_reg(REG_TEMP_WARN, tw[15:0]);
        write_reg(REG_STABLE_TIME, st[15:0]);
        if (k == 0 || k == 5) begin
            write_reg(REG_SPARE_LO, 16'h8000);
            write_reg(REG_SPARE_HI, $urandom_range(0, 65535));
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_directed();
        send_tick(mk(0, 100, 100, 100, 100, 500, 500, 0));
        send_tick(mk(0, -32768, -32768, -32768, -32768, -32768, -32768, 0));
        send_tick(mk(0, 100, 100, 100, 100, 500, 500, 10));
        send_tick(mk(0, 100, 100, 100, 100, 500, 500, 12));
        send_tick(mk(0, 100, 100, 100, 100, 500, 500, 13));
        send_tick(mk(0, 100, 100, 100, 100, 500, 500, 20));
        send_tick(mk(0, 100, 481, 100, 100, 500, 500, 21));
        send_tick(mk(0, 100, 100, 100, 100, 500, 1281, 22));
        send_tick(mk(0, 100, 100, 100, 801, 500, 500, 23));
        send_tick(mk(0, 100, 100, 100, 100, 1441, 500, 24));
        send_tick(mk(0, 32767, 100, 100, 100, 500, 500, 25));
        send_tick(mk(0, 100, 100, 32767, 100, 500, 32767, 26));
        send_tick(mk(1, 32767, 32767, 32767, 32767, 32767, 32767, 27));
        send_tick(mk(0, 100, 100, 100, 801, 500, 500, 28));
        send_tick(mk(1, -32768, -32768, -32768, -32768, -32768, -32768, 32'hFFFF_FFFF));
        send_tick(mk(0, 481, 100, 100, 100, 500, 500, 30));
        send_tick(mk(0, 100, 100, 100, 100, 500, 500, 31));
        send_tick(mk(0, 100, 100, 481, 100, 500, 500, 32));
        send_tick(mk(0, 480, 480, 480, 480, 1280, 1280, 33));
        send_tick(mk(0, -1, -32768, -32768, -32768, -32768, -32768, 34));
        send_tick(mk(0, 100, 100, 100, 100, 1281, 500, 35));
        send_tick(mk(0, 100, 100, 100, 100, 1281, 500, 36));
        send_tick(mk(0, 100, 100, 100, 100, 500, 500, 32'hFFFF_FFFE));
        send_tick(mk(0, 100, 100, 100, 100, 500, 500, 32'h0000_0001));
        send_tick(mk(0, 32767, 32767, 32767, 32767, 32767, 32767, 32'hFFFF_FFFF));
    endtask

    // Advance the millisecond clock: mostly small steps, sometimes zero or a jump.
    task automatic step_clock();
        int r;
        int step_max;
        r        = $urandom_range(0, 99);
        step_max = int'(ledger.stable_time) / 3 + 2;
        if (r < 3)
            tick_ms = '0;
        else if (r < 6)
            tick_ms = $urandom;
        else if (r < 8)
            tick_ms = 32'hFFFF_FFFF - $urandom_range(0, step_max * 2);
        else
            tick_ms = tick_ms + $urandom_range(0, step_max);
    endtask

    // kind: 0 safe, 1 warn, 2 limp, 3 fault, 4 noise
    task automatic make_tick(int kind, output item_t it);
        int vals[6];
        int cmin;
        int tmin;
        int hot;
        int lo;
        int hi;
        cmin = (ledger.cur_limp < ledger.cur_warn) ? ledger.cur_limp : ledger.cur_warn;
        tmin = (ledger.temp_limp < ledger.temp_warn) ? ledger.temp_limp : ledger.temp_warn;
        for (int s = 0; s < 6; s++)
        begin
            if (kind == 4)
                vals[s] = $urandom_range(0, 65535);
            else
                vals[s] = at_most((s < 4) ? cmin : tmin);
        end
        hot = $urandom_range(0, 5);
        lo  = (hot < 4) ? ledger.cur_warn : ledger.temp_warn;
        hi  = (hot < 4) ? ledger.cur_limp : ledger.temp_limp;
        if (kind == 1 || kind == 3)
            vals[hot] = between(lo, hi);
        else if (kind == 2)
            vals[hot] = between(hi, 32767);
        step_clock();
        it = mk((kind == 3) || (kind == 4 && $urandom_range(0, 3) == 0),
                vals[0], vals[1], vals[2], vals[3], vals[4], vals[5], tick_ms);
    endtask

    task automatic run_random(int count);
        int    sent;
        int    kind;
        int    run_len;
        int    r;
        bit    paused;
        item_t it;
        sent   = 0;
        paused = 1'b0;
        while (sent < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                kind = 0; run_len = $urandom_range(2, 12);
            end
            else if (r < 60) begin
                kind = 1; run_len = $urandom_range(1, 4);
            end
            else if (r < 78) begin
                kind = 2; run_len = $urandom_range(1, 5);
            end
            else if (r < 85) begin
                kind = 3; run_len = $urandom_range(1, 2);
            end
            else begin
                kind = 4; run_len = $urandom_range(1, 4);
            end
            for (int i = 0; i < run_len && sent < count; i++)
            begin
                make_tick(kind, it);
                send_tick(it);
                sent++;
            end
            // hold the sender once mid-phase until the pipe is empty
            if (!paused && sent >= count / 2) begin
                paused = 1'b1;
                settle();
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        send_idle_pct  = 14;
        recv_stall_pct = 73;
        tick_ms        = 32'd1;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        fault_latched <= 1'b0;
        current_a     <= '0;
        current_b     <= '0;
        current_c     <= '0;
        current_d     <= '0;
        temp_left     <= '0;
        temp_right    <= '0;
        now_ms        <= '0;
        out_ready     <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_setting(0);
        run_directed();
        settle();
        repeat (PIPE_LATENCY + 2) @(posedge clk);

        for (int k = 1; k <= 6; k++)
        begin
            if (k == 3) begin
                send_idle_pct  = 73;
                recv_stall_pct = 14;
            end
            else if (k == 5) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            apply_setting(k);
            run_random(PHASE_ITEMS);
            settle();
            repeat (PIPE_LATENCY + 2) @(posedge clk);
        end

        if (ledger.pending() != 0)
            ledger.report_mismatch("verdicts left over", ledger.pending(), 0);
        if (ledger.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
